// ===== sv/clbs_pkg.sv =====
// ----------------------------------------------------------------------------
// clbs_pkg
// Shared types and constants of the character LCD bus sequencer.
// ----------------------------------------------------------------------------
package clbs_pkg;

  // Request codes on the cmd field
  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_INSTR  = 2'd1,
    CMD_DATA   = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_FOUR_BIT  = 2'd0;
  localparam logic [1:0] CFG_EN_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_CYC_PER_US = 2'd2;

  localparam logic [7:0] CFG_EN_WIDTH_RST  = 8'd4;
  localparam logic [6:0] CFG_CYC_PER_US_RST = 7'd16;

  // Job kinds handed from the front end to the phase sequencer
  typedef enum logic [1:0] {
    JOB_REJECT = 2'd0,
    JOB_INIT   = 2'd1,
    JOB_POLL   = 2'd2,
    JOB_SAMPLE = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       four;   // bus mode for this job
    logic       busy;   // busy flag seen on a sample
    logic [7:0] wbyte;  // byte to write after a clear sample
    logic       rs;     // register select for that write
  } job_t;

  typedef struct packed {
    logic        four_bit_mode;
    logic [7:0]  enable_width;
    logic [6:0]  cycles_per_us;
  } cfg_t;

  localparam int HOLD_W = 20;
  localparam logic [HOLD_W-1:0] HOLD_MAX = 20'hFFFFF;

  typedef struct packed {
    logic              reg_select;
    logic              read_not_write;
    logic              enable;
    logic              bus_drive;
    logic [7:0]        bus_out;
    logic [HOLD_W-1:0] hold_cycles;
    logic              sample_now;
    logic              rejected;
    logic              last;
  } phase_t;

  // Function set values
  localparam logic [7:0] FSET_8BIT = 8'h30;
  localparam logic [7:0] FSET_4BIT = 8'h20;
  localparam logic [7:0] TWO_LINES = 8'h08;

  // Init waits in microseconds
  localparam int US_W = 14;
  localparam logic [US_W-1:0] US_POWER_UP = 14'd15000;
  localparam logic [US_W-1:0] US_FSET_1ST = 14'd5000;
  localparam logic [US_W-1:0] US_FSET     = 14'd150;

  localparam int BUSY_BIT = 7;

  // Default queue depths
  localparam int JOB_DEPTH_DEF = 2;
  localparam int RES_DEPTH_DEF = 4;

endpackage

// ===== sv/clbs_fifo.sv =====
// ----------------------------------------------------------------------------
// clbs_fifo
// Small show-ahead FIFO; the head entry is visible while empty is low.
// ----------------------------------------------------------------------------
module clbs_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/clbs_front.sv =====
// ----------------------------------------------------------------------------
// clbs_front
// Request front end: classifies each request and tracks the pending write.
// ----------------------------------------------------------------------------
module clbs_front
  import clbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] cmd,
  input  logic [7:0] value,
  input  logic [7:0] bus_in,
  input  logic       four_bit_mode,
  output logic       job_push,
  output job_t       job
);

  logic       await_sample;
  logic [7:0] pending_byte;
  logic       pending_rs;
  cmd_t       code;

  assign code = cmd_t'(cmd);

  always_comb begin
    job       = '0;
    job.four  = four_bit_mode;
    job.busy  = bus_in[BUSY_BIT];
    job.wbyte = pending_byte;
    job.rs    = pending_rs;
    job_push  = accept;
    if (code == CMD_SAMPLE) begin
      job.kind = JOB_SAMPLE;
      // drop a sample nobody asked for
      job_push = accept && await_sample;
    end else if (await_sample) begin
      job.kind = JOB_REJECT;
    end else if (code == CMD_INIT) begin
      job.kind = JOB_INIT;
    end else begin
      job.kind = JOB_POLL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      await_sample <= 1'b0;
      pending_byte <= '0;
      pending_rs   <= 1'b0;
    end else if (job_push) begin
      unique case (job.kind)
        JOB_SAMPLE: begin
          if (!job.busy) begin
            await_sample <= 1'b0;
          end
        end
        JOB_INIT: begin
          await_sample <= 1'b1;
          pending_byte <= (four_bit_mode ? FSET_4BIT : FSET_8BIT) | TWO_LINES;
          pending_rs   <= 1'b0;
        end
        JOB_POLL: begin
          await_sample <= 1'b1;
          pending_byte <= value;
          pending_rs   <= (code == CMD_DATA);
        end
        JOB_REJECT: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/clbs_back.sv =====
// ----------------------------------------------------------------------------
// clbs_back
// Phase sequencer: walks the head job one pin phase per cycle unless res_full.
// ----------------------------------------------------------------------------
module clbs_back
  import clbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   job_valid,
  input  job_t   job,
  output logic   job_pop,
  input  logic   res_full,
  output logic   res_push,
  output phase_t phase
);

  logic [4:0]        step;
  logic [4:0]        base;
  logic [2:0]        rel;
  logic [7:0]        tcyc;
  logic [HOLD_W-1:0] thold;
  logic              use_us;
  logic [US_W-1:0]   us_sel;
  logic [20:0]       prod;
  phase_t            ph;

  assign tcyc  = (cfg.enable_width == '0) ? 8'd1 : cfg.enable_width;
  assign thold = HOLD_W'(tcyc);
  assign prod  = 21'(us_sel) * 21'(cfg.cycles_per_us);

  always_comb begin
    ph     = '0;
    use_us = 1'b0;
    us_sel = US_FSET;
    base   = '0;
    rel    = '0;
    unique case (job.kind)
      JOB_REJECT: begin
        ph.rejected = 1'b1;
        ph.last     = 1'b1;
      end
      JOB_POLL: begin
        ph.read_not_write = 1'b1;
        ph.hold_cycles    = thold;
        ph.enable         = step[0];
        ph.sample_now     = step[0];
        ph.last           = step[0];
      end
      JOB_INIT: begin
        base = job.four ? 5'd13 : 5'd10;
        if (step >= base) begin
          // busy poll ahead of the final function set
          ph.read_not_write = 1'b1;
          ph.hold_cycles    = thold;
          ph.enable         = (step != base);
          ph.sample_now     = (step != base);
          ph.last           = (step != base);
        end else if (step == '0) begin
          ph.bus_drive = 1'b1;
          use_us       = 1'b1;
          us_sel       = US_POWER_UP;
        end else begin
          ph.bus_drive   = 1'b1;
          ph.bus_out     = (step >= 5'd10) ? FSET_4BIT : FSET_8BIT;
          ph.hold_cycles = thold;
          unique case (step)
            5'd2, 5'd5, 5'd8, 5'd11: ph.enable = 1'b1;
            5'd3, 5'd6, 5'd9, 5'd12: begin
              use_us = 1'b1;
              us_sel = (step == 5'd3) ? US_FSET_1ST : US_FSET;
            end
            default: begin
            end
          endcase
        end
      end
      JOB_SAMPLE: begin
        base = job.four ? 5'd3 : 5'd1;
        rel  = 3'(step - base);
        ph.hold_cycles = thold;
        if (step < base) begin
          ph.read_not_write = 1'b1;
          ph.enable         = step[0];
        end else if (job.busy) begin
          ph.read_not_write = 1'b1;
          ph.enable         = 1'b1;
          ph.sample_now     = 1'b1;
          ph.last           = 1'b1;
        end else begin
          ph.reg_select = job.rs;
          ph.bus_drive  = 1'b1;
          if (job.four) begin
            ph.bus_out = (rel < 3'd2) ? {job.wbyte[7:4], 4'b0000}
                                      : {job.wbyte[3:0], 4'b0000};
            ph.enable  = (rel == 3'd1) || (rel == 3'd3);
            ph.last    = (rel == 3'd4);
          end else begin
            ph.bus_out = job.wbyte;
            ph.enable  = (rel == 3'd1);
            ph.last    = (rel == 3'd2);
          end
        end
      end
      default: begin
      end
    endcase
    if (use_us) begin
      ph.hold_cycles = prod[20] ? HOLD_MAX : prod[HOLD_W-1:0];
    end
  end

  assign phase    = ph;
  assign res_push = job_valid && !res_full;
  assign job_pop  = res_push && ph.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (res_push) begin
      step <= ph.last ? '0 : step + 1'b1;
    end
  end

endmodule

// ===== sv/char_lcd_bus_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer
// Character LCD bus sequencer, 8-bit or 4-bit bus, with busy-flag handshake.
// ----------------------------------------------------------------------------
// Each request becomes a run of pin phases (RS, RW, E, drive, bus value and
// hold cycles), delivered one item per phase on the result queue, with last
// set on the final phase of the run. Every instruction, data or closing init
// function-set write is preceded by a busy-flag read whose final phase
// carries sample_now; feed the bus value seen during that phase back as a
// busy sample request. Until it arrives, other requests come back as a
// single item with rejected set. A request is taken whenever the job queue
// has room (full low); the phase sequencer then emits one phase per cycle
// while the result queue has room, and a request expands to 1 phase
// (reject), 2 (write request), 2 to 8 (sample) or 12 or 15 (init). The job
// queue lets requests keep arriving while a run is expanded, and the result
// queue lets the sequencer run ahead of pop. Configuration writes are always
// taken (cfg_ready high); write them only while the block is idle. Init waits
// are microseconds times cycles_per_us, saturating at the 20-bit hold limit.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer
  import clbs_pkg::*;
#(
  parameter int JOB_DEPTH = JOB_DEPTH_DEF,
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  value,
  input  logic [7:0]  bus_in,
  // configuration side
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic        reg_select,
  output logic        read_not_write,
  output logic        enable,
  output logic        bus_drive,
  output logic [7:0]  bus_out,
  output logic [19:0] hold_cycles,
  output logic        sample_now,
  output logic        rejected,
  output logic        last
);

  cfg_t   cfg;
  logic   accept;
  logic   job_push;
  job_t   job_in;
  job_t   job_head;
  logic   job_empty;
  logic   job_pop;
  logic   res_full;
  logic   res_push;
  phase_t phase_in;
  phase_t phase_head;

  // Configuration registers; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.four_bit_mode <= 1'b0;
      cfg.enable_width  <= CFG_EN_WIDTH_RST;
      cfg.cycles_per_us <= CFG_CYC_PER_US_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FOUR_BIT:   cfg.four_bit_mode <= cfg_data[0];
        CFG_EN_WIDTH:   cfg.enable_width  <= cfg_data;
        CFG_CYC_PER_US: cfg.cycles_per_us <= cfg_data[6:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Take a request whenever the job queue has room.
  assign accept = push && !full;

  clbs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (cmd),
    .value         (value),
    .bus_in        (bus_in),
    .four_bit_mode (cfg.four_bit_mode),
    .job_push      (job_push),
    .job           (job_in)
  );

  // Hold classified jobs between the front end and the sequencer.
  clbs_fifo #(
    .DEPTH (JOB_DEPTH),
    .WIDTH ($bits(job_t))
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .din   (job_in),
    .full  (full),
    .rd    (job_pop),
    .dout  (job_head),
    .empty (job_empty)
  );

  clbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (!job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .phase     (phase_in)
  );

  // Result queue decouples the sequencer from the consumer.
  clbs_fifo #(
    .DEPTH (RES_DEPTH),
    .WIDTH ($bits(phase_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .din   (phase_in),
    .full  (res_full),
    .rd    (pop),
    .dout  (phase_head),
    .empty (empty)
  );

  assign reg_select     = phase_head.reg_select;
  assign read_not_write = phase_head.read_not_write;
  assign enable         = phase_head.enable;
  assign bus_drive      = phase_head.bus_drive;
  assign bus_out        = phase_head.bus_out;
  assign hold_cycles    = phase_head.hold_cycles;
  assign sample_now     = phase_head.sample_now;
  assign rejected       = phase_head.rejected;
  assign last           = phase_head.last;

endmodule

// ===== sv/clbs_checker.sv =====
// ----------------------------------------------------------------------------
// clbs_checker
// Port-level checks of the LCD bus sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module clbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        reg_select,
  input logic        read_not_write,
  input logic        enable,
  input logic        bus_drive,
  input logic [7:0]  bus_out,
  input logic [19:0] hold_cycles,
  input logic        sample_now,
  input logic        rejected,
  input logic        last
);

  // A reject is a lone, blank phase.
  a_reject_blank: assert property (@(posedge clk) disable iff (rst)
    (!empty && rejected) |-> (last && !enable && !bus_drive && !read_not_write
                              && !reg_select && !sample_now && hold_cycles == '0))
    else $error("reject phase not blank");

  // The sample phase is the enable-high end of a busy read.
  a_sample_read: assert property (@(posedge clk) disable iff (rst)
    (!empty && sample_now) |-> (read_not_write && enable && last && !bus_drive))
    else $error("sample phase malformed");

  // Released pins carry zero.
  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !bus_drive) |-> (bus_out == 8'h00))
    else $error("bus value while released");

  // A waiting result holds until taken.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(bus_out) && $stable(hold_cycles)
                          && $stable(last)))
    else $error("result changed while waiting");

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (.*);
